@@ hdl/hb44_pkg.sv @@
package hb44_pkg;

  localparam int unsigned NumPix = 16;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned MaxShift = 11;

  localparam logic [KeyW-1:0]  ExpMask   = 16'h7c00;
  localparam logic [KeyW-1:0]  SignBit   = 16'h8000;
  localparam logic [KeyW-1:0]  RoundAdd  = 16'h0008;
  localparam logic [KeyW-1:0]  RoundMask = 16'hfff0;
  localparam logic [KeyW-1:0]  MaxClamp  = 16'hfbf0;
  localparam logic [CodeW-1:0] CodeMax   = 5'h1f;

  typedef logic [KeyW-1:0] key_t;

  // Map a half-float pattern to a key that sorts like the value.
  function automatic key_t order_key(input logic [15:0] h);
    key_t k;
    if ((h & ExpMask) == ExpMask) begin
      k = SignBit;
    end else if (h[15]) begin
      k = ~h;
    end else begin
      k = h | SignBit;
    end
    return k;
  endfunction

endpackage

@@ hdl/half_block_4x4_lossy_encoder.sv @@
// 4x4 half-float block encoder.
// Input stream (s_axis_*): one request per 4x4 block, four rows of four
// 16-bit half-float patterns. Output stream (m_axis_*): one 12-byte
// compressed block per request, in the same order.
// Pipeline: key/group max, block max rounding, differences/group max,
// shift selection, rounding and packing into the output register.
// Depth: five register stages, the last one being the output register.
// Throughput: one block per cycle while the receiver takes results.
// Every stage has its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles are squeezed out and a new request
// is taken while a result still waits.
// Reset (rst, synchronous, active high) empties every stage; data
// registers keep their contents but are marked invalid.
// When the receiver holds m_axis_tready low, the output register holds its
// block, the stages behind it fill up, and s_axis_tready drops only once
// all of them are full. Nothing is lost or repeated.
module half_block_4x4_lossy_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row0 [63:0], row1 [127:64], row2 [191:128], row3 [255:192]
  input  logic [255:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // head_bytes [63:0], tail_bytes [95:64]
  output logic [95:0] m_axis_tdata
);

  localparam int unsigned N  = hb44_pkg::NumPix;
  localparam int unsigned KW = hb44_pkg::KeyW;
  localparam int unsigned CW = hb44_pkg::CodeW;
  localparam int unsigned SW = hb44_pkg::ShiftW;

  // Stage valids and advance enables.
  logic v1, v2, v3, v4;
  logic ce1, ce2, ce3, ce4;

  // Stage 1: keys and per-row maximum.
  hb44_pkg::key_t key1 [N];
  hb44_pkg::key_t gmax1 [4];
  hb44_pkg::key_t key1_next [N];
  hb44_pkg::key_t gmax1_next [4];

  // Stage 2: keys and rounded block maximum.
  hb44_pkg::key_t key2 [N];
  hb44_pkg::key_t tmax2;
  hb44_pkg::key_t tmax2_next;

  // Stage 3: differences and per-row maximum difference.
  hb44_pkg::key_t dif3 [N];
  hb44_pkg::key_t gdmax3 [4];
  hb44_pkg::key_t tmax3;
  hb44_pkg::key_t dif3_next [N];
  hb44_pkg::key_t gdmax3_next [4];

  // Stage 4: differences and chosen shift.
  hb44_pkg::key_t dif4 [N];
  hb44_pkg::key_t tmax4;
  logic [SW-1:0]  shift4;
  logic [SW-1:0]  shift4_next;

  // Output stage.
  logic [95:0] m_axis_tdata_next;

  // A stage loads when it is empty or its successor takes its contents.
  assign ce4 = !m_axis_tvalid || m_axis_tready;
  assign ce3 = !v4 || ce4;
  assign ce2 = !v3 || ce3;
  assign ce1 = !v2 || ce2;
  assign s_axis_tready = !v1 || ce1;

  // Stage 1 logic: map patterns to keys, take the maximum of each row.
  always_comb begin
    hb44_pkg::key_t m;
    for (int i = 0; i < N; i++) begin
      key1_next[i] = hb44_pkg::order_key(s_axis_tdata[16*i +: 16]);
    end
    for (int g = 0; g < 4; g++) begin
      m = key1_next[4*g];
      for (int j = 1; j < 4; j++) begin
        if (key1_next[4*g+j] > m) m = key1_next[4*g+j];
      end
      gmax1_next[g] = m;
    end
  end

  // Stage 2 logic: block maximum, round to 12 bits, clamp below NaN range.
  always_comb begin
    hb44_pkg::key_t m;
    hb44_pkg::key_t r;
    m = gmax1[0];
    for (int g = 1; g < 4; g++) begin
      if (gmax1[g] > m) m = gmax1[g];
    end
    r = (m + hb44_pkg::RoundAdd) & hb44_pkg::RoundMask;
    tmax2_next = (r > hb44_pkg::MaxClamp) ? hb44_pkg::MaxClamp : r;
  end

  // Stage 3 logic: differences from the maximum, zero where key is above.
  always_comb begin
    hb44_pkg::key_t m;
    for (int i = 0; i < N; i++) begin
      dif3_next[i] = (key2[i] >= tmax2) ? '0 : KW'(tmax2 - key2[i]);
    end
    for (int g = 0; g < 4; g++) begin
      m = dif3_next[4*g];
      for (int j = 1; j < 4; j++) begin
        if (dif3_next[4*g+j] > m) m = dif3_next[4*g+j];
      end
      gdmax3_next[g] = m;
    end
  end

  // Stage 4 logic: smallest shift of at least one that fits the largest
  // difference into five bits.
  always_comb begin
    hb44_pkg::key_t m;
    m = gdmax3[0];
    for (int g = 1; g < 4; g++) begin
      if (gdmax3[g] > m) m = gdmax3[g];
    end
    shift4_next = SW'(hb44_pkg::MaxShift);
    for (int s = hb44_pkg::MaxShift; s >= 1; s--) begin
      if ((m >> s) <= KW'(hb44_pkg::CodeMax)) shift4_next = SW'(s);
    end
  end

  // Stage 5 logic: round, shift, saturate and pack the codes.
  always_comb begin
    logic [KW:0]      sum;
    logic [KW:0]      half;
    logic [KW:0]      q;
    logic [CW-1:0]    code [N];
    logic [8*CW-1:0]  lo_codes;
    logic [8*CW-1:0]  hi_codes;
    half = (KW+1)'(1) << (shift4 - SW'(1));
    for (int i = 0; i < N; i++) begin
      sum = {1'b0, dif4[i]} + half;
      q = sum >> shift4;
      code[i] = (q > (KW+1)'(hb44_pkg::CodeMax)) ? hb44_pkg::CodeMax : q[CW-1:0];
    end
    for (int i = 0; i < 8; i++) begin
      lo_codes[CW*(7-i) +: CW] = code[i];
      hi_codes[CW*(7-i) +: CW] = code[8+i];
    end
    // Head: max key with shift in its low nibble, d0..d7, top byte of d8..d15.
    m_axis_tdata_next[63:0]  = {tmax4[KW-1:4], shift4, lo_codes, hi_codes[39:32]};
    // Tail: the remaining bits of d8..d15.
    m_axis_tdata_next[95:64] = hi_codes[31:0];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) v1 <= s_axis_tvalid;
      if (ce1) v2 <= v1;
      if (ce2) v3 <= v2;
      if (ce3) v4 <= v3;
      if (ce4) m_axis_tvalid <= v4;
    end
  end

  // Data registers; hold while the stage is stalled.
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      key1  <= key1_next;
      gmax1 <= gmax1_next;
    end
    if (ce1) begin
      key2  <= key1;
      tmax2 <= tmax2_next;
    end
    if (ce2) begin
      dif3   <= dif3_next;
      gdmax3 <= gdmax3_next;
      tmax3  <= tmax2;
    end
    if (ce3) begin
      dif4   <= dif3;
      tmax4  <= tmax3;
      shift4 <= shift4_next;
    end
    if (ce4) begin
      m_axis_tdata <= m_axis_tdata_next;
    end
  end

endmodule

@@ tb/sv/hb44_tb_pkg.sv @@
package hb44_tb_pkg;

  localparam logic [15:0] ExpOnes   = 16'h7c00;
  localparam logic [15:0] PosKeyBit = 16'h8000;
  localparam logic [16:0] HalfStep  = 17'h00008;
  localparam logic [15:0] StepMask  = 16'hfff0;
  localparam logic [15:0] TopClamp  = 16'hfbf0;
  localparam logic [4:0]  CodeSat   = 5'h1f;

  typedef struct packed {
    logic [63:0] head;
    logic [31:0] tail;
  } coded_block_t;

  class encoded_block_book;
    coded_block_t pending[$];
    int unsigned  mismatches;
    int unsigned  blocks_noted;
    int unsigned  clamped_blocks;
    int unsigned  special_blocks;
    logic [15:0]  shifts_seen;

    function new();
      mismatches     = 0;
      blocks_noted   = 0;
      clamped_blocks = 0;
      special_blocks = 0;
      shifts_seen    = '0;
    endfunction

    // Compress one 4x4 block into its 12-byte form.
    function coded_block_t encode_block(input logic [255:0] blk);
      logic [15:0]  pix;
      logic [15:0]  key [16];
      logic [15:0]  dif [16];
      logic [4:0]   code [16];
      logic [15:0]  peak;
      logic [15:0]  top;
      logic [15:0]  dmax;
      logic [16:0]  sum;
      logic [3:0]   sh;
      logic [95:0]  stream;
      coded_block_t res;
      bit           saw_special;
      int           i;
      peak = '0;
      saw_special = 1'b0;
      for (i = 0; i < 16; i++) begin
        pix = blk[16*i +: 16];
        if ((pix & ExpOnes) == ExpOnes) begin
          key[i] = PosKeyBit;
          saw_special = 1'b1;
        end else if (pix[15]) begin
          key[i] = ~pix;
        end else begin
          key[i] = pix | PosKeyBit;
        end
        if (key[i] > peak) peak = key[i];
      end
      // Round the peak to 12 bits; the carry out of bit 15 is dropped.
      sum = {1'b0, peak} + HalfStep;
      top = sum[15:0] & StepMask;
      if (top > TopClamp) begin
        top = TopClamp;
        clamped_blocks++;
      end
      dmax = '0;
      for (i = 0; i < 16; i++) begin
        dif[i] = (key[i] >= top) ? 16'h0000 : top - key[i];
        if (dif[i] > dmax) dmax = dif[i];
      end
      sh = 4'd1;
      while ((dmax >> sh) > 16'(CodeSat)) sh++;
      for (i = 0; i < 16; i++) begin
        sum = ({1'b0, dif[i]} + (17'd1 << (sh - 4'd1))) >> sh;
        code[i] = (sum > 17'(CodeSat)) ? CodeSat : sum[4:0];
      end
      stream = {top[15:4], sh, 80'b0};
      for (i = 0; i < 16; i++) stream[79-5*i -: 5] = code[i];
      res.head = stream[95:32];
      res.tail = stream[31:0];
      shifts_seen[sh] = 1'b1;
      if (saw_special) special_blocks++;
      return res;
    endfunction

    function void note_request(input logic [255:0] blk);
      pending.push_back(encode_block(blk));
      blocks_noted++;
    endfunction

    function void check_result(input logic [95:0] data);
      coded_block_t want;
      if (pending.size() == 0) begin
        $error("unexpected output block: head_bytes %h tail_bytes %h",
               data[63:0], data[95:64]);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (data[63:0] !== want.head) begin
        $error("head_bytes mismatch: expected %h, actual %h", want.head, data[63:0]);
        mismatches++;
      end
      if (data[95:64] !== want.tail) begin
        $error("tail_bytes mismatch: expected %h, actual %h", want.tail, data[95:64]);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

endpackage

@@ tb/sv/tb_half_block_4x4_lossy_encoder.sv @@
module tb_half_block_4x4_lossy_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBlocks = 1300;
  localparam int CycleLimit   = 1000000;
  // Pipeline is five stages deep; give stray outputs time to show up.
  localparam int DrainCycles  = 20;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // row0 [63:0], row1 [127:64], row2 [191:128], row3 [255:192]
  logic [255:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // head_bytes [63:0], tail_bytes [95:64]
  logic [95:0]  m_axis_tdata;

  bit           calm = 1'b0;
  int unsigned  cycle_count = 0;

  hb44_tb_pkg::encoded_block_book book = new();

  half_block_4x4_lossy_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Build a random block: raw bits, tight clusters of nearby values,
  // special patterns, or clusters near the top of the finite range.
  function automatic logic [255:0] random_block();
    logic [255:0] blk;
    logic [15:0]  base;
    logic [15:0]  mask;
    logic [15:0]  px;
    int           mode;
    int           i;
    mode = $urandom_range(0, 9);
    base = 16'($urandom);
    mask = 16'((32'd1 << $urandom_range(0, 14)) - 1);
    if (mode >= 8) base = {1'b0, 5'b11110, base[9:0]};
    for (i = 0; i < 16; i++) begin
      case (mode)
        0, 1: px = 16'($urandom);
        7: begin
          case ($urandom_range(0, 7))
            0: px = 16'h7c00;
            1: px = 16'hfc00;
            2: px = {1'b0, 5'h1f, 10'($urandom_range(1, 1023))};
            3: px = {1'b1, 5'h1f, 10'($urandom)};
            4: px = 16'h7bff;
            5: px = 16'hfbff;
            6: px = {$urandom_range(0, 1) == 1, 15'h0000};
            default: px = 16'($urandom);
          endcase
        end
        default: begin
          px = base ^ (16'($urandom) & mask);
          // Flip sign now and then so blocks straddle zero.
          if ($urandom_range(0, 5) == 0) px[15] = ~px[15];
        end
      endcase
      blk[16*i +: 16] = px;
    end
    return blk;
  endfunction

  // Present one request after a random idle time, hold it until taken.
  task automatic send_block(input logic [255:0] blk);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk); while (!s_axis_tready);
    book.note_request(blk);
    @(negedge clk);
  endtask

  // Compare every output block the receiver takes.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
  end

  // Receiver: accept in runs, stall in between; no stalls while calm.
  initial begin : receiver
    int run;
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = calm ? 8 : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [255:0] directed[$];
    logic [255:0] blk;
    int           k;
    int           n;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Uniform blocks: zeros, NaN, both infinities, the finite extremes.
    directed.push_back({16{16'h0000}});
    directed.push_back({16{16'hffff}});
    directed.push_back({16{16'h7c00}});
    directed.push_back({16{16'hfc00}});
    directed.push_back({16{16'h7bff}});   // peak rounds past the clamp
    directed.push_back({16{16'hfbff}});
    // Wide spreads: the first reaches the largest shift, the second one below it.
    directed.push_back({{15{16'hfbff}}, 16'h7bff});
    directed.push_back({{15{16'h0000}}, 16'h7bff});
    // Difference of 63 at shift 1 rounds to 32 and saturates.
    directed.push_back({{15{16'h0001}}, 16'h0040});
    // Peak rounds down: keys above the rounded peak give zero.
    directed.push_back({{14{16'h0000}}, 16'h0003, 16'h0002});
    // Peak rounds up across a 16-step boundary.
    directed.push_back({{15{16'h0001}}, 16'h000f});
    // NaN among positives and among negatives.
    directed.push_back({{8{16'h7e00}}, {8{16'h3c00}}});
    directed.push_back({{8{16'hfe01}}, {8{16'hbc00}}});
    // Signed zeros.
    directed.push_back({8{16'h8000, 16'h0000}});
    directed.push_back({4{64'h5555aaaa5555aaaa}});
    directed.push_back({4{64'h0123456789abcdef}});
    // One outlier sized to land exactly on a given shift.
    for (k = 3; k <= 9; k += 2) begin
      blk = {16{16'h4000}};
      blk[16*5 +: 16] = 16'h4000 - (16'd63 << (k - 1));
      directed.push_back(blk);
    end
    foreach (directed[i]) send_block(directed[i]);

    for (n = 0; n < RandomBlocks; n++) begin
      // Hold two windows with neither side idling.
      calm = (n >= 400 && n < 480) || (n >= 900 && n < 960);
      send_block(random_block());
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every block still in flight, then watch for strays.
    while (book.pending_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d blocks encoded and compared; shift values reached (bit per shift): %b",
             book.blocks_noted, book.shifts_seen);
    $display("%0d blocks hit the top clamp, %0d carried NaN or infinity pixels",
             book.clamped_blocks, book.special_blocks);
    if (book.mismatches == 0 && book.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
